/* rtl/matrix_rotate_flip_undo_top_assert.svh */
// Assertion macros for the matrix rotate and flip block.
`ifndef MATRIX_ROTATE_FLIP_UNDO_TOP_ASSERT_SVH
`define MATRIX_ROTATE_FLIP_UNDO_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MRFU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mrfu assertion failed");
// Condition must never be true at a clock edge outside reset.
`define MRFU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mrfu forbidden condition seen");
`else
`define MRFU_ASSERT(lbl, clk, rst_n, prop)
`define MRFU_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/mrfu_pkg.sv */
// Shared types, constants and helpers of the matrix rotate and flip block.
`default_nettype none

package mrfu_pkg;

  // Sizing of the matrix store and the operation list.
  localparam int MAX_DIM    = 8;
  localparam int MAX_OPS    = 64;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // Field and register widths.
  localparam int ELEM_W     = 32;
  localparam int DIM_W      = 4;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int LOAD_W     = 7;
  localparam int OPCNT_W    = 7;
  localparam int OPSEQ_W    = 64;
  localparam int OPIDX_W    = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Operation codes carried in the sequence register.
  localparam logic OP_ROTATE = 1'b0;
  localparam logic OP_FLIP   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT   = 2'd0,
    REG_COL_COUNT   = 2'd1,
    REG_OP_COUNT    = 2'd2,
    REG_OP_SEQUENCE = 2'd3
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_XFORM,
    ST_READ,
    ST_SHOW
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;
    logic xform_start;
    logic xform_step;
    logic read_en;
    logic emit_adv;
  } mrfu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_done;
    logic ops_done;
    logic last;
  } mrfu_sts_t;

  // Out-of-range dimensions: zero reads as one, large values saturate.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/mrfu_ctrl.sv */
// Controller state machine: load, transform composition, read and present.
`default_nettype none

module mrfu_ctrl import mrfu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_stall_i,
  input  mrfu_sts_t sts_i,
  output mrfu_cmd_t cmd_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && sts_i.load_done) begin
          state_d = ST_XFORM;
        end
      end
      ST_XFORM: begin
        if (sts_i.ops_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (!out_stall_i) begin
          state_d = sts_i.last ? ST_LOAD : ST_READ;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o        = 1'b0;
        cmd_o.load_en     = in_valid_i;
        cmd_o.xform_start = in_valid_i && sts_i.load_done;
      end
      ST_XFORM: begin
        cmd_o.xform_step = !sts_i.ops_done;
      end
      ST_READ: begin
        cmd_o.read_en = 1'b1;
      end
      ST_SHOW: begin
        out_valid_o    = 1'b1;
        cmd_o.emit_adv = !out_stall_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mrfu_dp.sv */
// Datapath: configuration, matrix store, transform composition and readout.
`default_nettype none

module mrfu_dp import mrfu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic signed [ELEM_W-1:0] elem_value_i,
  input  mrfu_cmd_t                cmd_i,
  output mrfu_sts_t                sts_o,
  output logic signed [ELEM_W-1:0] out_value_o,
  output logic [DIM_W-1:0]         out_rows_o,
  output logic [DIM_W-1:0]         out_cols_o,
  output logic                     last_elem_o
);

  logic [DIM_W-1:0]   row_count_q, col_count_q;
  logic [OPCNT_W-1:0] op_count_q;
  logic [OPSEQ_W-1:0] op_seq_q;

  logic [ELEM_W-1:0]  store_q [DEPTH];
  logic [ELEM_W-1:0]  rdata_q;

  logic [LOAD_W-1:0]  load_cnt_q, load_next;
  logic [OPCNT_W-1:0] op_cnt_q, op_cnt_m1, nops;
  logic               swap_q, flip_i_q, flip_j_q, op_bit;
  logic [IDX_W-1:0]   row_q, col_q, x_idx, y_idx;

  logic [DIM_W-1:0]   nr, nc, o_rows, o_cols, src_i, src_j;
  logic [LOAD_W-1:0]  total;
  logic [PROD_W-1:0]  prod, addr_full;
  logic [ADDR_W-1:0]  rd_addr;
  logic               col_end, row_end;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= DIM_W'(1);
      col_count_q <= DIM_W'(1);
      op_count_q  <= '0;
      op_seq_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROW_COUNT:   row_count_q <= cfg_data_i[DIM_W-1:0];
        REG_COL_COUNT:   col_count_q <= cfg_data_i[DIM_W-1:0];
        REG_OP_COUNT:    op_count_q  <= cfg_data_i[OPCNT_W-1:0];
        REG_OP_SEQUENCE: op_seq_q    <= cfg_data_i[OPSEQ_W-1:0];
        default: begin
          op_seq_q <= op_seq_q;
        end
      endcase
    end
  end

  // Effective dimensions, element count and operation count.
  always_comb begin
    nr    = clamp_dim(row_count_q);
    nc    = clamp_dim(col_count_q);
    prod  = {{DIM_W{1'b0}}, nr} * {{DIM_W{1'b0}}, nc};
    total = prod[LOAD_W-1:0];
    nops  = (op_count_q > OPCNT_W'(MAX_OPS)) ? OPCNT_W'(MAX_OPS) : op_count_q;
  end

  // Load counter; the matrix completes once the count reaches the element total.
  assign load_next       = load_cnt_q + LOAD_W'(1);
  assign sts_o.load_done = (load_next >= total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (cmd_i.load_en) begin
      load_cnt_q <= cmd_i.xform_start ? '0 : load_next;
    end
  end

  // Matrix store, written in load order and read at the source address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en && (load_cnt_q < LOAD_W'(DEPTH))) begin
      store_q[load_cnt_q[ADDR_W-1:0]] <= elem_value_i;
    end
    if (cmd_i.read_en) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  // Transform composition: operations walk from the last one to the first and
  // update a swap flag and two mirror flags that map output to source positions.
  assign op_cnt_m1      = op_cnt_q - OPCNT_W'(1);
  assign op_bit         = op_seq_q[op_cnt_m1[OPIDX_W-1:0]];
  assign sts_o.ops_done = (op_cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_cnt_q <= '0;
      swap_q   <= 1'b0;
      flip_i_q <= 1'b0;
      flip_j_q <= 1'b0;
    end else if (cmd_i.xform_start) begin
      op_cnt_q <= nops;
      swap_q   <= 1'b0;
      flip_i_q <= 1'b0;
      flip_j_q <= 1'b0;
    end else if (cmd_i.xform_step) begin
      op_cnt_q <= op_cnt_m1;
      if (op_bit == OP_FLIP) begin
        // A flip mirrors whichever source axis lies along the current rows.
        if (swap_q) begin
          flip_j_q <= !flip_j_q;
        end else begin
          flip_i_q <= !flip_i_q;
        end
      end else begin
        // A counterclockwise turn mirrors the axis that moves to the rows and swaps.
        if (swap_q) begin
          flip_i_q <= !flip_i_q;
        end else begin
          flip_j_q <= !flip_j_q;
        end
        swap_q <= !swap_q;
      end
    end
  end

  // Output dimensions follow the swap flag.
  assign o_rows = swap_q ? nc : nr;
  assign o_cols = swap_q ? nr : nc;

  // Output position counters, row-major over the transformed matrix.
  assign col_end    = (DIM_W'(col_q) == o_cols - DIM_W'(1));
  assign row_end    = (DIM_W'(row_q) == o_rows - DIM_W'(1));
  assign sts_o.last = col_end && row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.xform_start) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.emit_adv) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_q + IDX_W'(1);
      end else begin
        col_q <= col_q + IDX_W'(1);
      end
    end
  end

  // Source address of the current output position.
  always_comb begin
    x_idx     = swap_q ? col_q : row_q;
    y_idx     = swap_q ? row_q : col_q;
    src_i     = flip_i_q ? (nr - DIM_W'(1) - DIM_W'(x_idx)) : DIM_W'(x_idx);
    src_j     = flip_j_q ? (nc - DIM_W'(1) - DIM_W'(y_idx)) : DIM_W'(y_idx);
    addr_full = {{DIM_W{1'b0}}, src_i} * {{DIM_W{1'b0}}, nc}
              + {{DIM_W{1'b0}}, src_j};
    rd_addr   = addr_full[ADDR_W-1:0];
  end

  // Result payload; it holds while the output stalls.
  assign out_value_o = rdata_q;
  assign out_rows_o  = o_rows;
  assign out_cols_o  = o_cols;
  assign last_elem_o = sts_o.last;

endmodule

`default_nettype wire

/* rtl/matrix_rotate_flip_undo_top.sv */
// Load accepts one element per cycle, one element per transaction, with no stall.
// After the completing element, the controller composes the operations in turn,
// with op_count capped at 64; each result then passes a store read state and a
// presentation state, and is held while the output stalls.
// Reset clears configuration to its defaults, the load count and the controller;
// the matrix store is not cleared and needs no clearing pass.
`default_nettype none

`include "matrix_rotate_flip_undo_top_assert.svh"

module matrix_rotate_flip_undo_top import mrfu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [ELEM_W-1:0] elem_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ELEM_W-1:0] out_value_o,
  output logic [DIM_W-1:0]         out_rows_o,
  output logic [DIM_W-1:0]         out_cols_o,
  output logic                     last_elem_o
);

  mrfu_cmd_t cmd;
  mrfu_sts_t sts;

  // Controller.
  mrfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Datapath.
  mrfu_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .elem_value_i (elem_value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_value_o  (out_value_o),
    .out_rows_o   (out_rows_o),
    .out_cols_o   (out_cols_o),
    .last_elem_o  (last_elem_o)
  );

  // No input transaction is taken while a result is on offer.
  `MRFU_ASSERT_NEVER(a_no_load_during_emit, clk_i, rst_ni, out_valid_o && !in_stall_o)

  // A completing element stops further input until the matrix is emitted.
  `MRFU_ASSERT(a_stall_after_complete, clk_i, rst_ni, (in_valid_i && !in_stall_o && sts.load_done) |=> in_stall_o)

  // Taking the last result reopens the input in the next cycle.
  `MRFU_ASSERT(a_ready_after_last, clk_i, rst_ni, (out_valid_o && !out_stall_i && last_elem_o) |=> !in_stall_o)

  // Composition steps are only issued while operations remain.
  `MRFU_ASSERT_NEVER(a_step_without_ops, clk_i, rst_ni, cmd.xform_step && sts.ops_done)

endmodule

`default_nettype wire

/* test/matrix_rotate_flip_undo_top_test.sv */
// Self-checking testbench for the matrix rotate and flip block, with its own transform predictor.
`timescale 1ns / 100ps

module matrix_rotate_flip_undo_top_test import mrfu_pkg::*;;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 80;
  localparam int RANDOM_ITEMS  = 20;

  // Receiver behaviors for the output channel.
  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURSTY
  } stall_mode_e;

  // One element of a transformed matrix as the block presents it.
  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic              last;
  } elem_out_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i   = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic signed [ELEM_W-1:0] elem_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic signed [ELEM_W-1:0] out_value_o;
  logic [DIM_W-1:0]         out_rows_o;
  logic [DIM_W-1:0]         out_cols_o;
  logic                     last_elem_o;

  // Shadow copy of the configuration registers and of the matrix store.
  logic [DIM_W-1:0]   cfg_rows  = DIM_W'(1);
  logic [DIM_W-1:0]   cfg_cols  = DIM_W'(1);
  logic [OPCNT_W-1:0] cfg_nops  = '0;
  logic [OPSEQ_W-1:0] cfg_opseq = '0;
  logic [ELEM_W-1:0]  model_store [DEPTH];
  int                 load_cnt  = 0;

  elem_out_t   expected_elems [$];
  elem_out_t   want_elem;
  int          errors      = 0;
  int          elems_sent  = 0;
  int          burst_left  = 0;
  int          gap_max     = 3;
  stall_mode_e stall_mode  = STALL_RANDOM;
  int          stall_run   = 0;

  matrix_rotate_flip_undo_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elem_value_i (elem_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .out_rows_o   (out_rows_o),
    .out_cols_o   (out_cols_o),
    .last_elem_o  (last_elem_o)
  );

  // Free-running clock.
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // A zero dimension counts as one and large ones saturate at the largest dimension.
  function automatic int dim_limit(input logic [DIM_W-1:0] raw);
    int d;
    d = int'(raw);
    if (d < 1) begin
      d = 1;
    end else if (d > MAX_DIM) begin
      d = MAX_DIM;
    end
    return d;
  endfunction

  // Stores one accepted element; on the completing one, transforms and queues the matrix.
  task automatic accept_elem(input logic [ELEM_W-1:0] v);
    int nr, nc, total, nops, k, i, j, t;
    logic [ELEM_W-1:0] work [DEPTH];
    elem_out_t e;
    nr    = dim_limit(cfg_rows);
    nc    = dim_limit(cfg_cols);
    total = nr * nc;
    nops  = (int'(cfg_nops) > MAX_OPS) ? MAX_OPS : int'(cfg_nops);
    if (load_cnt < DEPTH) begin
      model_store[load_cnt] = v;
    end
    load_cnt = (load_cnt + 1) % (1 << LOAD_W);
    if (load_cnt >= total) begin
      // The operations are undone from the last one back to the first.
      for (k = nops - 1; k >= 0; k--) begin
        if (cfg_opseq[k] == OP_FLIP) begin
          for (i = 0; i < nr; i++) begin
            for (j = 0; j < nc; j++) begin
              work[(nr - 1 - i) * nc + j] = model_store[i * nc + j];
            end
          end
        end else begin
          for (i = 0; i < nr; i++) begin
            for (j = 0; j < nc; j++) begin
              work[(nc - 1 - j) * nr + i] = model_store[i * nc + j];
            end
          end
          t  = nr;
          nr = nc;
          nc = t;
        end
        for (i = 0; i < total; i++) begin
          model_store[i] = work[i];
        end
      end
      for (k = 0; k < total; k++) begin
        e.value = model_store[k];
        e.rows  = DIM_W'(nr);
        e.cols  = DIM_W'(nc);
        e.last  = (k == total - 1);
        expected_elems.push_back(e);
      end
      load_cnt = 0;
    end
  endtask

  // Random element value that often lands on the extremes.
  function automatic logic [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Random raw dimension: mostly small, sometimes zero or above the largest dimension.
  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? DIM_W'(0) : DIM_W'($urandom_range(9, 15));
    end
    return DIM_W'($urandom_range(1, 4));
  endfunction

  // Sends one element transaction; the sender pauses between bursts of random length.
  task automatic send_elem(input logic [ELEM_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i   = 1'b1;
    elem_value_i = v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accept_elem(v);
    elems_sent++;
    @(negedge clk_i);
  endtask

  // Sends random elements until the open matrix completes.
  task automatic finish_matrix();
    do begin
      send_elem(pick_elem());
    end while (load_cnt != 0);
  endtask

  // Drops valid and waits until every queued element has come out and the block is quiet.
  task automatic settle();
    in_valid_i = 1'b0;
    while (expected_elems.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes one configuration register and mirrors it in the shadow copy.
  task automatic set_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_ROW_COUNT: cfg_rows = data[DIM_W-1:0];
      REG_COL_COUNT: cfg_cols = data[DIM_W-1:0];
      REG_OP_COUNT:  cfg_nops = data[OPCNT_W-1:0];
      default:       cfg_opseq = data[OPSEQ_W-1:0];
    endcase
  endtask

  // Waits for the block to go idle, then writes all four registers.
  task automatic configure(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                           input logic [OPCNT_W-1:0] nops, input logic [OPSEQ_W-1:0] seq);
    settle();
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
    set_reg(REG_COL_COUNT, CFG_DATA_W'(cols));
    set_reg(REG_OP_COUNT, CFG_DATA_W'(nops));
    set_reg(REG_OP_SEQUENCE, CFG_DATA_W'(seq));
  endtask

  // Reset configuration: single-element matrices with no operations.
  task automatic test_reset_defaults();
    send_elem(32'h8000_0000);
    send_elem(32'h7fff_ffff);
  endtask

  // One flip on a column and one rotation on a row.
  task automatic test_single_ops();
    configure(DIM_W'(2), DIM_W'(1), OPCNT_W'(1), 64'h1);
    send_elem(32'h8000_0000);
    send_elem(32'h7fff_ffff);
    configure(DIM_W'(1), DIM_W'(3), OPCNT_W'(1), 64'h0);
    send_elem(32'h0000_0000);
    send_elem(32'hffff_ffff);
    send_elem(32'h5a5a_a5a5);
  endtask

  // Zero and oversized dimensions, and an operation count above the maximum.
  task automatic test_clamped_config();
    stall_mode = STALL_BURSTY;
    configure(DIM_W'(0), DIM_W'(2), OPCNT_W'(127), {$urandom, $urandom});
    finish_matrix();
    configure(DIM_W'(12), DIM_W'(0), OPCNT_W'(65), 64'haaaa_aaaa_5555_5555);
    finish_matrix();
  endtask

  // Matrix size changed while a load is open: once shrinking, once growing.
  task automatic test_config_midway();
    stall_mode = STALL_NONE;
    configure(DIM_W'(2), DIM_W'(3), OPCNT_W'(1), 64'h0);
    repeat (3) send_elem(pick_elem());
    settle();
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(1));
    finish_matrix();
    configure(DIM_W'(1), DIM_W'(2), OPCNT_W'(2), 64'h2);
    send_elem(pick_elem());
    settle();
    set_reg(REG_COL_COUNT, CFG_DATA_W'(3));
    finish_matrix();
  endtask

  // Random configurations, mostly small matrices, with random idling on both sides.
  task automatic test_random_matrices();
    int start, nops, total, head;
    logic [OPSEQ_W-1:0] seq;
    start = elems_sent;
    while (elems_sent < start + RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       seq = '0;
        1:       seq = '1;
        default: seq = {$urandom, $urandom};
      endcase
      nops = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
      configure(pick_dim(), pick_dim(), OPCNT_W'(nops), seq);
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      gap_max    = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
      repeat ($urandom_range(1, 3)) begin
        total = dim_limit(cfg_rows) * dim_limit(cfg_cols);
        if (total > 1 && $urandom_range(0, 4) == 0) begin
          // Part of the matrix goes in, then the size changes under the open load.
          head = $urandom_range(1, total - 1);
          repeat (head) send_elem(pick_elem());
          settle();
          set_reg(REG_ROW_COUNT, CFG_DATA_W'(pick_dim()));
          set_reg(REG_COL_COUNT, CFG_DATA_W'(pick_dim()));
        end
        finish_matrix();
      end
    end
  endtask

  // Largest matrix with the longest operation list.
  task automatic test_full_size();
    configure(DIM_W'(8), DIM_W'(8), OPCNT_W'(MAX_OPS), {$urandom, $urandom});
    stall_mode = STALL_BURSTY;
    gap_max    = 2;
    finish_matrix();
  endtask

  // Output stall pattern, changed at the falling edge.
  always @(negedge clk_i) begin
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (stall_run > 0) begin
          stall_run   <= stall_run - 1;
          out_stall_i <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_run   <= $urandom_range(1, 6);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    endcase
  end

  // Every accepted output transaction is compared with the oldest queued element.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_elems.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, value %0d", $time, out_value_o);
      end else begin
        want_elem = expected_elems.pop_front();
        if (out_value_o !== want_elem.value) begin
          errors++;
          $display("%0t: out_value mismatch, expected %0d, actual %0d",
                   $time, $signed(want_elem.value), out_value_o);
        end
        if (out_rows_o !== want_elem.rows) begin
          errors++;
          $display("%0t: out_rows mismatch, expected %0d, actual %0d",
                   $time, want_elem.rows, out_rows_o);
        end
        if (out_cols_o !== want_elem.cols) begin
          errors++;
          $display("%0t: out_cols mismatch, expected %0d, actual %0d",
                   $time, want_elem.cols, out_cols_o);
        end
        if (last_elem_o !== want_elem.last) begin
          errors++;
          $display("%0t: last_elem mismatch, expected %0b, actual %0b",
                   $time, want_elem.last, last_elem_o);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_single_ops();
    test_clamped_config();
    test_config_midway();
    test_random_matrices();
    test_full_size();
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mrfu_pkg.sv
rtl/mrfu_ctrl.sv
rtl/mrfu_dp.sv
rtl/matrix_rotate_flip_undo_top.sv
test/matrix_rotate_flip_undo_top_test.sv
